// ----- hw/rtl/cffp_pkg.sv -----
package cffp_pkg;

   // time base of the burst and release bookkeeping
   localparam int TIME_BITS = 48;
   // fixed port field widths
   localparam int NOW_W = 48;
   localparam int DLC_W = 4;
   localparam int ID_W = 32;
   localparam int IVAL_W = 24;
   localparam int BITS_W = 7;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 128;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   // frame length terms
   localparam logic [BITS_W-1:0] FRAME_BASE_BITS = 7'd33;
   localparam logic [BITS_W-1:0] EXT_ID_BITS = 7'd29;
   localparam logic [BITS_W-1:0] STD_ID_BITS = 7'd11;
   localparam logic [DLC_W-1:0] MAX_DATA_BYTES = 4'd8;
   localparam int ID_EXT_BIT = 31;

   // rate mode arithmetic: bits * 1e8 / (bitrate * rate)
   localparam logic [IVAL_W-1:0] INTERVAL_MAX = 24'hFFFFFF;
   localparam int NUM_W = 34;
   localparam int DEN_W = 27;
   localparam int REM_W = DEN_W + 1;
   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [DEN_W-1:0] RATE_SCALE = 27'd100000000;
   localparam logic [7:0] RATE_MIN = 8'd1;
   localparam logic [7:0] RATE_MAX = 8'd100;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RATE_MODE      = 3'd0,
      REG_FIXED_INTERVAL = 3'd1,
      REG_BUS_BITRATE    = 3'd2,
      REG_RATE_PERCENT   = 3'd3,
      REG_BURST_ENABLE   = 3'd4,
      REG_BURST_LENGTH   = 3'd5,
      REG_BURST_PAUSE    = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic                rate_mode;
      logic [IVAL_W-1:0]   fixed_interval;
      logic [19:0]         bus_bitrate;
      logic [7:0]          rate_percent;
      logic                burst_enable;
      logic [31:0]         burst_length;
      logic [31:0]         burst_pause;
   } cfg_type;

   // classified frame passed from front to back
   typedef struct packed {
      logic [TIME_BITS-1:0] now;
      logic [BITS_W-1:0]    bits;
   } item_type;

endpackage

// ----- hw/rtl/cffp_front.sv -----
module cffp_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_us [47:0], data_length [51:48], frame_id [83:52], zero fill
   input  logic [cffp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                push_valid,
   input  logic                                push_ready,
   output cffp_pkg::item_type                  push_item
);

   logic                    hold_valid_ff, hold_valid_in;
   cffp_pkg::item_type      item_ff, item_in;
   logic [cffp_pkg::NOW_W-1:0] now_us;
   logic [cffp_pkg::DLC_W-1:0] data_length;
   logic [cffp_pkg::ID_W-1:0]  frame_id;
   logic [cffp_pkg::DLC_W-1:0] bytes;
   logic [cffp_pkg::BITS_W-1:0] id_bits;

   assign now_us      = req_tdata[cffp_pkg::NOW_W-1:0];
   assign data_length = req_tdata[cffp_pkg::NOW_W +: cffp_pkg::DLC_W];
   assign frame_id    = req_tdata[cffp_pkg::NOW_W + cffp_pkg::DLC_W +: cffp_pkg::ID_W];

   // classic CAN: data length codes above eight still carry eight bytes
   assign bytes   = (data_length > cffp_pkg::MAX_DATA_BYTES) ? cffp_pkg::MAX_DATA_BYTES
                                                            : data_length;
   assign id_bits = frame_id[cffp_pkg::ID_EXT_BIT] ? cffp_pkg::EXT_ID_BITS
                                                   : cffp_pkg::STD_ID_BITS;

   assign req_tready = !hold_valid_ff || push_ready;
   assign push_valid = hold_valid_ff;
   assign push_item  = item_ff;

   // holding stage: classify on accept, hand on to the queue
   always_comb begin
      hold_valid_in = hold_valid_ff;
      item_in       = item_ff;
      if (push_valid && push_ready) begin
         hold_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         hold_valid_in = 1'b1;
         item_in.now   = cffp_pkg::TIME_BITS'(now_us);
         item_in.bits  = cffp_pkg::FRAME_BASE_BITS + {bytes, 3'b000} + id_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ----- hw/rtl/cffp_queue.sv -----
module cffp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  cffp_pkg::item_type  push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output cffp_pkg::item_type  pop_item
);

   cffp_pkg::item_type               entry_ff [cffp_pkg::QUEUE_DEPTH];
   logic [cffp_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [cffp_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [cffp_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             push_fire;
   logic                             pop_fire;

   assign push_ready = (count_ff != cffp_pkg::QCNT_W'(cffp_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cffp_pkg::QCNT_W'(cffp_pkg::QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_push_pop_hold: assert property (@(posedge clock) disable iff (reset)
      (push_fire && pop_fire) |=> (count_ff == $past(count_ff)))
      else $error("queue fill changed on simultaneous push and pop");

endmodule

// ----- hw/rtl/cffp_back.sv -----
module cffp_back (
   input  logic                             clock,
   input  logic                             reset,
   input  cffp_pkg::cfg_type                cfg,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  cffp_pkg::item_type               pop_item,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic                             rsp_paused,
   output logic [cffp_pkg::NOW_W-1:0]       rsp_send,
   output logic [cffp_pkg::NOW_W-1:0]       rsp_next,
   output logic [cffp_pkg::IVAL_W-1:0]      rsp_ival,
   output logic [cffp_pkg::BITS_W-1:0]      rsp_bits
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_BURST = 4'b0100,
      ST_FIN   = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   cffp_pkg::item_type                 item_ff, item_in;
   logic [cffp_pkg::NUM_W-1:0]         dvd_ff, dvd_in;
   logic [cffp_pkg::DEN_W-1:0]         den_ff, den_in;
   logic [cffp_pkg::REM_W-1:0]         rem_ff, rem_in;
   logic [cffp_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic                               pause_ff, pause_in;
   logic [cffp_pkg::IVAL_W-1:0]        ival_ff, ival_in;
   logic [cffp_pkg::TIME_BITS-1:0]     deadline_ff, deadline_in;
   logic [cffp_pkg::TIME_BITS-1:0]     release_ff, release_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_paused_ff, rsp_paused_in;
   logic [cffp_pkg::NOW_W-1:0]         rsp_send_ff, rsp_send_in;
   logic [cffp_pkg::NOW_W-1:0]         rsp_next_ff, rsp_next_in;
   logic [cffp_pkg::IVAL_W-1:0]        rsp_ival_ff, rsp_ival_in;
   logic [cffp_pkg::BITS_W-1:0]        rsp_bits_ff, rsp_bits_in;

   logic [7:0]                         rate_clamped;
   logic [cffp_pkg::NUM_W-1:0]         num_load;
   logic [cffp_pkg::DEN_W-1:0]         den_load;
   logic [cffp_pkg::REM_W-1:0]         rem_shift;
   logic                               quo_bit;
   logic [31:0]                        blen;
   logic [31:0]                        bpause;
   logic                               use_rate;
   logic                               quo_sat;
   logic                               out_free;
   logic [cffp_pkg::TIME_BITS-1:0]     release_sum;
   logic [cffp_pkg::TIME_BITS-1:0]     send_time;

   // per-bit time operands, clamped rate
   assign rate_clamped = (cfg.rate_percent < cffp_pkg::RATE_MIN) ? cffp_pkg::RATE_MIN :
                         (cfg.rate_percent > cffp_pkg::RATE_MAX) ? cffp_pkg::RATE_MAX :
                                                                  cfg.rate_percent;
   assign num_load = cffp_pkg::NUM_W'(pop_item.bits) * cffp_pkg::NUM_W'(cffp_pkg::RATE_SCALE);
   assign den_load = cffp_pkg::DEN_W'(cfg.bus_bitrate) * cffp_pkg::DEN_W'(rate_clamped);

   // one restoring division step
   assign rem_shift = {rem_ff[cffp_pkg::REM_W-2:0], dvd_ff[cffp_pkg::NUM_W-1]};
   assign quo_bit   = (rem_shift >= {1'b0, den_ff});

   // zero burst length or pause takes the other
   assign blen   = (cfg.burst_length != '0) ? cfg.burst_length : cfg.burst_pause;
   assign bpause = (cfg.burst_pause != '0) ? cfg.burst_pause : cfg.burst_length;

   assign use_rate    = cfg.rate_mode && (cfg.bus_bitrate != '0);
   assign quo_sat     = |dvd_ff[cffp_pkg::NUM_W-1:cffp_pkg::IVAL_W];
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign release_sum = release_ff + cffp_pkg::TIME_BITS'(ival_ff);
   assign send_time   = (pause_ff && (deadline_ff > item_ff.now)) ? deadline_ff : item_ff.now;

   assign pop_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      dvd_in        = dvd_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      pause_in      = pause_ff;
      ival_in       = ival_ff;
      deadline_in   = deadline_ff;
      release_in    = release_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_paused_in = rsp_paused_ff;
      rsp_send_in   = rsp_send_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_ival_in   = rsp_ival_ff;
      rsp_bits_in   = rsp_bits_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // take the next frame and load the divider
            if (pop_valid) begin
               item_in  = pop_item;
               dvd_in   = num_load;
               den_in   = den_load;
               rem_in   = '0;
               cnt_in   = cffp_pkg::CNT_W'(cffp_pkg::NUM_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = quo_bit ? (rem_shift - {1'b0, den_ff}) : rem_shift;
            dvd_in = {dvd_ff[cffp_pkg::NUM_W-2:0], quo_bit};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_BURST;
            end
         end
         ST_BURST: begin
            // pick the interval, then arm the burst timer or take a pause
            if (!use_rate) begin
               ival_in = cfg.fixed_interval;
            end else if (quo_sat) begin
               ival_in = cffp_pkg::INTERVAL_MAX;
            end else begin
               ival_in = dvd_ff[cffp_pkg::IVAL_W-1:0];
            end
            pause_in = 1'b0;
            if (cfg.burst_enable) begin
               if (deadline_ff == '0) begin
                  deadline_in = cffp_pkg::TIME_BITS'(blen);
               end else if (item_ff.now >= deadline_ff) begin
                  pause_in    = 1'b1;
                  deadline_in = deadline_ff + cffp_pkg::TIME_BITS'(bpause);
                  release_in  = release_ff + cffp_pkg::TIME_BITS'(bpause);
               end
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // commit state and present the result once the output slot frees
            if (out_free) begin
               if (pause_ff) begin
                  deadline_in = deadline_ff + cffp_pkg::TIME_BITS'(blen);
               end
               release_in    = release_sum;
               rsp_valid_in  = 1'b1;
               rsp_paused_in = pause_ff;
               rsp_send_in   = cffp_pkg::NOW_W'(send_time);
               rsp_next_in   = cffp_pkg::NOW_W'(release_sum);
               rsp_ival_in   = ival_ff;
               rsp_bits_in   = item_ff.bits;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         deadline_ff  <= '0;
         release_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         deadline_ff  <= deadline_in;
         release_ff   <= release_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      dvd_ff        <= dvd_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      pause_ff      <= pause_in;
      ival_ff       <= ival_in;
      rsp_paused_ff <= rsp_paused_in;
      rsp_send_ff   <= rsp_send_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_ival_ff   <= rsp_ival_in;
      rsp_bits_ff   <= rsp_bits_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_paused = rsp_paused_ff;
   assign rsp_send   = rsp_send_ff;
   assign rsp_next   = rsp_next_ff;
   assign rsp_ival   = rsp_ival_ff;
   assign rsp_bits   = rsp_bits_ff;

   a_result_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside the commit step");

   a_pause_needs_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_paused_ff) |-> cfg.burst_enable)
      else $error("pause reported with bursts disabled");

   a_fixed_interval: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !cfg.rate_mode) |-> (rsp_ival_ff == cfg.fixed_interval))
      else $error("fixed mode interval mismatch");

endmodule

// ----- hw/rtl/can_flood_frame_pacer_top.sv -----
// Path: an accepted item passes the front register, the queue, the divider load, 34 divide
//   steps, the burst step and the commit, which waits until the result channel is free.
// Flow: the back end takes one item at a time, held by the one-bit-per-cycle restoring
//   divider for the rate-mode interval; a two-entry queue lets the front take items meanwhile.
// Reset: synchronous, active high; clears the queue, the pipeline, the burst deadline
//   and the release time, and loads the register defaults.
module can_flood_frame_pacer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_us [47:0], data_length [51:48], frame_id [83:52], zero fill
   input  logic [cffp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // send_time_us [47:0], next_release_us [95:48], interval_us [119:96],
   // frame_bits [126:120], zero fill
   output logic [cffp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // paused [0]
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [cffp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cffp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   cffp_pkg::cfg_type                cfg_ff, cfg_in;
   logic                             push_valid;
   logic                             push_ready;
   cffp_pkg::item_type               push_item;
   logic                             pop_valid;
   logic                             pop_ready;
   cffp_pkg::item_type               pop_item;
   logic [cffp_pkg::NOW_W-1:0]       rsp_send;
   logic [cffp_pkg::NOW_W-1:0]       rsp_next;
   logic [cffp_pkg::IVAL_W-1:0]      rsp_ival;
   logic [cffp_pkg::BITS_W-1:0]      rsp_bits;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (cffp_pkg::csr_reg_type'(csr_index))
            cffp_pkg::REG_RATE_MODE:      cfg_in.rate_mode      = csr_wdata[0];
            cffp_pkg::REG_FIXED_INTERVAL: cfg_in.fixed_interval = csr_wdata[23:0];
            cffp_pkg::REG_BUS_BITRATE:    cfg_in.bus_bitrate    = csr_wdata[19:0];
            cffp_pkg::REG_RATE_PERCENT:   cfg_in.rate_percent   = csr_wdata[7:0];
            cffp_pkg::REG_BURST_ENABLE:   cfg_in.burst_enable   = csr_wdata[0];
            cffp_pkg::REG_BURST_LENGTH:   cfg_in.burst_length   = csr_wdata;
            cffp_pkg::REG_BURST_PAUSE:    cfg_in.burst_pause    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_mode      <= 1'b0;
         cfg_ff.fixed_interval <= 24'd1000;
         cfg_ff.bus_bitrate    <= 20'd500000;
         cfg_ff.rate_percent   <= 8'd100;
         cfg_ff.burst_enable   <= 1'b0;
         cfg_ff.burst_length   <= '0;
         cfg_ff.burst_pause    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cffp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   cffp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   cffp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_paused (rsp_tuser),
      .rsp_send   (rsp_send),
      .rsp_next   (rsp_next),
      .rsp_ival   (rsp_ival),
      .rsp_bits   (rsp_bits)
   );

   assign rsp_tdata = {1'b0, rsp_bits, rsp_ival, rsp_next, rsp_send};

endmodule
